@@ rtl/ifp_pkg.sv @@
// Shared constants and types for the IMU frame parser.
package ifp_pkg;

  // Framing
  localparam int SYNC_LENGTH     = 4;
  localparam int FRAME_LENGTH    = 34;
  localparam int NUM_CH          = 12;
  localparam int FIRST_WORD_BYTE = 9;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  // Sum of the sync bytes, the checksum's starting value
  localparam logic [7:0] SYNC_SUM  = 8'((SYNC_LENGTH * 255) % 256);

  // Register file
  localparam int SCALE_W = 26;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_FS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd4;

  localparam logic [SCALE_W-1:0] GYRO_FS_RST     = 26'd29491200;
  localparam logic [SCALE_W-1:0] ACCEL_FS_RST    = 26'd196608;
  localparam logic [SCALE_W-1:0] MAG_FS_RST      = 26'd93389;
  localparam logic [SCALE_W-1:0] TEMP_SLOPE_RST  = 26'd39009524;
  localparam logic [SCALE_W-1:0] TEMP_OFFSET_RST = 26'd1638400;

  // Channel numbering
  localparam logic [3:0] CH_ACCEL0 = 4'd3;
  localparam logic [3:0] CH_MAG0   = 4'd6;
  localparam logic [3:0] CH_TEMP0  = 4'd9;
  localparam logic [3:0] CH_LAST   = 4'(NUM_CH - 1);

  // Frame queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic [NUM_CH-1:0][15:0] words;
    logic [7:0]              message_id;
    logic [15:0]             sample_time;
    logic                    checksum_ok;
  } frame_t;

  typedef struct packed {
    logic [SCALE_W-1:0] gyro_fs;
    logic [SCALE_W-1:0] accel_fs;
    logic [SCALE_W-1:0] mag_fs;
    logic [SCALE_W-1:0] temp_slope;
    logic [SCALE_W-1:0] temp_offset;
  } scale_cfg_t;

endpackage

@@ rtl/ifp_front.sv @@
// Byte-level front end: sync hunt, frame capture and checksum.
module ifp_front import ifp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       push,
  output frame_t     frame
);

  localparam logic [5:0] LAST_POS   = 6'(FRAME_LENGTH - 1);
  localparam logic [5:0] WORD_FIRST = 6'(FIRST_WORD_BYTE);
  localparam logic [5:0] WORD_END   = 6'(FIRST_WORD_BYTE + 2 * NUM_CH);

  logic        in_frame;
  logic [2:0]  sync_run;
  logic [5:0]  pos;
  logic [7:0]  sum;
  logic [7:0]  msg_id;
  logic [15:0] timer;
  word_t       words [NUM_CH];

  logic        at_check;
  logic        accept;
  logic [2:0]  run_inc;
  logic [5:0]  wofs;
  logic        in_words;
  logic [3:0]  widx;

  assign at_check = in_frame && (pos == LAST_POS);
  // only the checksum byte needs room in the queue
  assign rx_stall = at_check && q_full;
  assign accept   = rx_valid && !rx_stall;
  assign push     = accept && at_check;
  assign run_inc  = sync_run + 3'd1;
  assign wofs     = pos - WORD_FIRST;
  assign in_words = (pos >= WORD_FIRST) && (pos < WORD_END);
  assign widx     = wofs[4:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      sync_run <= '0;
      pos      <= '0;
      sum      <= '0;
      msg_id   <= '0;
      timer    <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == SYNC_BYTE) begin
          if (run_inc >= 3'(SYNC_LENGTH)) begin
            sync_run <= '0;
            in_frame <= 1'b1;
            pos      <= '0;
            sum      <= SYNC_SUM;
          end else begin
            sync_run <= run_inc;
          end
        end else begin
          sync_run <= '0;
        end
      end else if (at_check) begin
        in_frame <= 1'b0;
        pos      <= '0;
        sum      <= '0;
        sync_run <= '0;
      end else begin
        sum <= sum + rx_byte;
        pos <= pos + 6'd1;
        if (pos == 6'd0) begin
          msg_id <= rx_byte;
        end
        if (pos == 6'd3) begin
          timer[15:8] <= rx_byte;
        end
        if (pos == 6'd4) begin
          timer[7:0] <= rx_byte;
        end
      end
    end
  end

  // sample words: high byte first
  always_ff @(posedge clk) begin
    if (accept && in_frame && !at_check && in_words) begin
      if (!wofs[0]) begin
        words[widx] <= {rx_byte, 8'h00};
      end else begin
        words[widx][7:0] <= rx_byte;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      frame.words[k] = words[k];
    end
    frame.message_id  = msg_id;
    frame.sample_time = timer;
    frame.checksum_ok = (rx_byte == sum);
  end

endmodule

@@ rtl/ifp_queue.sv @@
// Short queue of captured frames between front and back end.
module ifp_queue import ifp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t wr_frame,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output frame_t rd_frame
);

  frame_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign rd_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ifp_back.sv @@
// Back end: walks the twelve channels of a frame, scales and emits them.
module ifp_back import ifp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  frame_t             head,
  output logic               pop,
  input  scale_cfg_t         cfg,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [3:0]         channel,
  output logic signed [15:0] raw_value,
  output logic signed [27:0] scaled_value,
  output logic [7:0]         message_id,
  output logic [15:0]        sample_time,
  output logic               checksum_ok,
  output logic               last_of_frame
);

  logic [3:0]          ch;
  logic                o_load;
  logic                p_load;
  logic                p_adv;
  logic                issue;
  word_t               sel_word;
  logic [SCALE_W-1:0]  sel_scale;
  logic signed [42:0]  prod;

  // multiply stage
  logic                p_valid;
  logic signed [42:0]  p_prod;
  logic [3:0]          p_ch;
  word_t               p_raw;
  logic [7:0]          p_id;
  logic [15:0]         p_time;
  logic                p_ok;
  logic                p_temp;

  assign o_load = !res_valid || !res_stall;
  assign p_adv  = p_valid && o_load;
  assign p_load = !p_valid || o_load;
  assign issue  = q_valid && p_load;
  assign pop    = issue && (ch == CH_LAST);

  always_comb begin
    sel_word = head.words[ch];
    if (ch < CH_ACCEL0) begin
      sel_scale = cfg.gyro_fs;
    end else if (ch < CH_MAG0) begin
      sel_scale = cfg.accel_fs;
    end else if (ch < CH_TEMP0) begin
      sel_scale = cfg.mag_fs;
    end else begin
      sel_scale = cfg.temp_slope;
    end
  end

  assign prod = $signed(sel_word) * $signed({1'b0, sel_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      ch        <= '0;
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (issue) begin
        ch <= (ch == CH_LAST) ? 4'd0 : ch + 4'd1;
      end
      if (p_load) begin
        p_valid <= issue;
      end
      if (o_load) begin
        res_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_prod <= prod;
      p_ch   <= ch;
      p_raw  <= sel_word;
      p_id   <= head.message_id;
      p_time <= head.sample_time;
      p_ok   <= head.checksum_ok;
      p_temp <= (ch >= CH_TEMP0);
    end
    if (p_adv) begin
      // arithmetic >>15 floors, matching the negative rounding
      scaled_value  <= p_prod[42:15] + (p_temp ? {2'b00, cfg.temp_offset} : 28'd0);
      channel       <= p_ch;
      raw_value     <= p_raw;
      message_id    <= p_id;
      sample_time   <= p_time;
      checksum_ok   <= p_ok;
      last_of_frame <= (p_ch == CH_LAST);
    end
  end

  a_ch_range: assert property (@(posedge clk) disable iff (rst) ch <= CH_LAST)
    else $error("channel counter out of range");

  a_last_ch: assert property (@(posedge clk) disable iff (rst)
    res_valid && last_of_frame |-> channel == CH_LAST)
    else $error("last_of_frame on wrong channel");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !o_load |=> p_valid && $stable(p_ch))
    else $error("multiply stage lost an item under stall");

  a_pop_wrap: assert property (@(posedge clk) disable iff (rst)
    pop |=> ch == 4'd0)
    else $error("channel counter not rewound after frame");

endmodule

@@ rtl/imu_frame_parser.sv @@
// Top level of the IMU frame parser: registers, front end, queue, back end.
// Input: one byte per cycle; stall only on the checksum byte when the frame queue is full.
// Results leave through the queue, the multiply stage and the output register once the
// checksum byte is taken, one per cycle while res_stall is low: twelve results per frame.
// Frame queue holds two frames, so output stalls reach the byte input only after that.
// Reset (rst, synchronous) returns the parser to sync hunting, empties the queue and
// output pipe and loads the default full-scale, slope and offset values.
module imu_frame_parser import ifp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // byte input
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  // results
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [3:0]           channel,
  output logic signed [15:0]   raw_value,
  output logic signed [27:0]   scaled_value,
  output logic [7:0]           message_id,
  output logic [15:0]          sample_time,
  output logic                 checksum_ok,
  output logic                 last_of_frame,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  scale_cfg_t cfg;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  frame_t     wr_frame;
  frame_t     head;

  // register port never stalls; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_fs     <= GYRO_FS_RST;
      cfg.accel_fs    <= ACCEL_FS_RST;
      cfg.mag_fs      <= MAG_FS_RST;
      cfg.temp_slope  <= TEMP_SLOPE_RST;
      cfg.temp_offset <= TEMP_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GYRO_FS:     cfg.gyro_fs     <= cfg_data;
        REG_ACCEL_FS:    cfg.accel_fs    <= cfg_data;
        REG_MAG_FS:      cfg.mag_fs      <= cfg_data;
        REG_TEMP_SLOPE:  cfg.temp_slope  <= cfg_data;
        REG_TEMP_OFFSET: cfg.temp_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sync hunt and frame capture; pushes a whole frame on the checksum byte
  ifp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .frame    (wr_frame)
  );

  // decouples byte intake from result delivery
  ifp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_frame (wr_frame),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .rd_frame (head)
  );

  // one channel per cycle through multiplier and output register, unless res_stall holds it
  ifp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .channel       (channel),
    .raw_value     (raw_value),
    .scaled_value  (scaled_value),
    .message_id    (message_id),
    .sample_time   (sample_time),
    .checksum_ok   (checksum_ok),
    .last_of_frame (last_of_frame)
  );

endmodule
